@@ hw/rtl/ffnact_pkg.sv @@
// ffnact_pkg: shared types, fixed-point constants and table builders for
// the feed-forward activation unit. No dependencies.
package ffnact_pkg;

  typedef enum logic {
    ACT_GELU   = 1'b0,
    ACT_SWIGLU = 1'b1
  } act_kind_e;

  localparam logic MODE_FWD = 1'b0;
  localparam logic MODE_BWD = 1'b1;

  localparam int unsigned TABLE_ENTRIES_DEF = 256;

  localparam logic signed [63:0] ONE_Q16   = 64'sd65536;
  localparam logic signed [63:0] SQ2PI_Q24 = 64'sd13386282;
  localparam logic signed [63:0] K044_Q24  = 64'sd750193;
  localparam logic signed [63:0] K134_Q24  = 64'sd2250579;
  localparam logic [63:0]        EINV_Q32  = 64'd1580030169;

  // round to nearest, ties away from zero
  function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] x,
                                                   input int unsigned sh);
    logic signed [63:0] half;
    half = 64'sd1 <<< (sh - 1);
    if (x >= 0) begin
      return (x + half) >>> sh;
    end
    return -((-x + half) >>> sh);
  endfunction

  // restoring unsigned division; only evaluated while building the tables
  function automatic logic [63:0] udiv64(input logic [63:0] num,
                                         input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], num[b]};
      if (r >= {1'b0, den}) begin
        r    = r - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // e^-t with t in Q32, result Q32; used only while building tables
  function automatic logic [63:0] exp_neg(input logic [63:0] t);
    logic [63:0] n;
    logic [63:0] f;
    logic [63:0] term;
    logic signed [63:0] sum;
    logic [63:0] e;
    n    = t >> 32;
    f    = t & 64'hFFFF_FFFF;
    term = 64'd1 << 32;
    sum  = 64'sd1 <<< 32;
    for (int k = 1; k <= 24; k++) begin
      term = udiv64((term * f) >> 32, 64'(k));
      if ((k & 1) == 1) begin
        sum = sum - signed'(term);
      end else begin
        sum = sum + signed'(term);
      end
    end
    e = unsigned'(sum);
    for (longint k = 0; k < longint'(n); k++) begin
      e = (e * EINV_Q32 + (64'd1 << 31)) >> 32;
    end
    return e;
  endfunction

  // sigmoid or tanh sample i of n over [-8,8), Q16
  function automatic logic signed [17:0] tab_entry(input int i, input int n,
                                                   input logic is_tanh);
    logic signed [63:0] p;
    logic [63:0] ap;
    logic [63:0] e;
    logic [63:0] d;
    logic [63:0] tv;
    p  = 64'sd16 * 64'(i) - 64'sd8 * 64'(n);
    ap = unsigned'(p < 0 ? -p : p);
    if (!is_tanh) begin
      e = exp_neg(udiv64(ap << 32, 64'(n)));
      d = (64'd1 << 32) + e;
      if (p >= 0) begin
        tv = udiv64((64'd1 << 48) + (d >> 1), d);
      end else begin
        tv = udiv64((e << 16) + (d >> 1), d);
      end
      return 18'(signed'(tv));
    end
    e  = exp_neg(udiv64(ap << 33, 64'(n)));
    d  = (64'd1 << 32) + e;
    tv = udiv64((((64'd1 << 32) - e) << 16) + (d >> 1), d);
    return p < 0 ? -18'(signed'(tv)) : 18'(signed'(tv));
  endfunction

endpackage

@@ hw/rtl/ffn_activation_unit.sv @@
// ffn_activation_unit: pipelined GELU / SwiGLU activation and its gradient
// in signed Q8.8. Depends on ffnact_pkg for constants and table builders.
//
// Usage: the input channel (in_valid_i / in_stall_o) carries one item per
// element: mode_i (0 forward, 1 backward), pre_activation_i, gate_value_i and
// upstream_grad_i. The output channel (out_valid_o / out_stall_i) returns
// main_result_o, gate_grad_o and saturated_o for each item, in order.
// cfg_we_i / cfg_wdata_i write activation_kind (0 GELU, 1 SwiGLU); write it
// only while no item is in flight.
// Throughput is one item per cycle while out_stall_i is low. The accepting
// edge loads the input capture stage and the 12 register stages after it
// hold the squaring, cubing, tanh/sigmoid table interpolation, gradient
// chain and the final rounding.
// Each stage advances when it is empty or the stage after it moves, so a
// stalled receiver backs the pipeline up one stage at a time and bubbles
// are squeezed out; in_stall_o rises only when every stage is full.
// Reset clears the valid bits and sets activation_kind to GELU; tables are
// constant logic, so no warm-up is needed.
module ffn_activation_unit #(
  parameter int unsigned TableEntries = ffnact_pkg::TABLE_ENTRIES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               mode_i,
  input  logic signed [15:0] pre_activation_i,
  input  logic signed [15:0] gate_value_i,
  input  logic signed [15:0] upstream_grad_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] main_result_o,
  output logic signed [15:0] gate_grad_o,
  output logic               saturated_o
);
  import ffnact_pkg::*;

  localparam int NumStages = 13;
  localparam int IdxW = $clog2(TableEntries);
  localparam logic signed [35:0] LimQ16 = 36'sd524288;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TableEntries - 1);

  typedef logic signed [17:0] tab_t [TableEntries];

  function automatic tab_t build_tab(input logic is_tanh);
    tab_t t;
    for (int i = 0; i < int'(TableEntries); i++) begin
      t[i] = tab_entry(i, int'(TableEntries), is_tanh);
    end
    return t;
  endfunction

  localparam tab_t SigTab  = build_tab(1'b0);
  localparam tab_t TanhTab = build_tab(1'b1);

  act_kind_e kind_q;
  logic      swi;
  logic [NumStages-1:0] vld_q;
  logic [NumStages-1:0] en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= ACT_GELU;
    end else if (cfg_we_i) begin
      kind_q <= act_kind_e'(cfg_wdata_i);
    end
  end

  assign swi = (kind_q == ACT_SWIGLU);

  // a stage moves when empty or when the next one moves
  always_comb begin
    en[NumStages-1] = !vld_q[NumStages-1] || !out_stall_i;
    for (int i = NumStages - 2; i >= 0; i--) begin
      en[i] = !vld_q[i] || en[i+1];
    end
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = vld_q[NumStages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int i = 1; i < NumStages; i++) begin
        if (en[i]) begin
          vld_q[i] <= vld_q[i-1];
        end
      end
    end
  end

  // stage 1: capture, v widened to Q16
  logic               s1_mode_q;
  logic signed [23:0] s1_v_q;
  logic signed [15:0] s1_gate_q, s1_g_q;
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s1_mode_q <= mode_i;
      s1_v_q    <= {pre_activation_i, 8'h00};
      s1_gate_q <= gate_value_i;
      s1_g_q    <= upstream_grad_i;
    end
  end

  // stage 2: v^2
  logic               s2_mode_q;
  logic signed [23:0] s2_v_q;
  logic signed [15:0] s2_gate_q, s2_g_q;
  logic signed [31:0] s2_sq_q;
  logic signed [63:0] t2_sq;
  assign t2_sq = rnd_shift(s1_v_q * s1_v_q, 16);
  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s2_mode_q <= s1_mode_q;
      s2_v_q    <= s1_v_q;
      s2_gate_q <= s1_gate_q;
      s2_g_q    <= s1_g_q;
      s2_sq_q   <= t2_sq[31:0];
    end
  end

  // stage 3: v^3 and the derivative of the inner cubic, 1 + 3*0.044715*v^2
  logic               s3_mode_q;
  logic signed [23:0] s3_v_q;
  logic signed [15:0] s3_gate_q, s3_g_q;
  logic signed [38:0] s3_cube_q;
  logic signed [29:0] s3_in2_q;
  logic signed [63:0] t3_cube, t3_in2;
  assign t3_cube = rnd_shift(s2_sq_q * s2_v_q, 16);
  assign t3_in2  = ONE_Q16 + rnd_shift(s2_sq_q * K134_Q24, 24);
  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      s3_mode_q <= s2_mode_q;
      s3_v_q    <= s2_v_q;
      s3_gate_q <= s2_gate_q;
      s3_g_q    <= s2_g_q;
      s3_cube_q <= t3_cube[38:0];
      s3_in2_q  <= t3_in2[29:0];
    end
  end

  // stage 4
  logic               s4_mode_q;
  logic signed [23:0] s4_v_q;
  logic signed [15:0] s4_gate_q, s4_g_q;
  logic signed [35:0] s4_inner_q;
  logic signed [29:0] s4_dinner_q;
  logic signed [63:0] t4_inner, t4_dinner;
  assign t4_inner  = s3_v_q + rnd_shift(s3_cube_q * K044_Q24, 24);
  assign t4_dinner = rnd_shift(s3_in2_q * SQ2PI_Q24, 24);
  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      s4_mode_q   <= s3_mode_q;
      s4_v_q      <= s3_v_q;
      s4_gate_q   <= s3_gate_q;
      s4_g_q      <= s3_g_q;
      s4_inner_q  <= t4_inner[35:0];
      s4_dinner_q <= t4_dinner[29:0];
    end
  end

  // stage 5: tanh argument
  logic               s5_mode_q;
  logic signed [23:0] s5_v_q;
  logic signed [15:0] s5_gate_q, s5_g_q;
  logic signed [35:0] s5_u_q;
  logic signed [29:0] s5_dinner_q;
  logic signed [63:0] t5_u;
  assign t5_u = rnd_shift(s4_inner_q * SQ2PI_Q24, 24);
  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      s5_mode_q   <= s4_mode_q;
      s5_v_q      <= s4_v_q;
      s5_gate_q   <= s4_gate_q;
      s5_g_q      <= s4_g_q;
      s5_u_q      <= t5_u[35:0];
      s5_dinner_q <= s4_dinner_q;
    end
  end

  // stage 6: table index and fraction
  logic               s6_mode_q;
  logic signed [23:0] s6_v_q;
  logic signed [15:0] s6_gate_q, s6_g_q;
  logic signed [29:0] s6_dinner_q;
  logic [IdxW-1:0]    s6_ka_q, s6_kb_q;
  logic [15:0]        s6_frac_q;
  logic signed [35:0] t6_arg, t6_clamp, t6_w;
  logic [63:0]        t6_pos, t6_k;
  logic               t6_last;
  always_comb begin
    t6_arg   = swi ? 36'(s5_v_q) : s5_u_q;
    t6_clamp = (t6_arg < -LimQ16) ? -LimQ16 : t6_arg;
    t6_w     = t6_clamp + LimQ16;
    t6_pos   = ({43'd0, t6_w[20:0]} * 64'(TableEntries)) >> 4;
    t6_k     = t6_pos >> 16;
    // at or above 8, or in the last interval: last entry, no interpolation
    t6_last  = (t6_arg >= LimQ16) || (t6_k >= 64'(TableEntries - 1));
  end
  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      s6_mode_q   <= s5_mode_q;
      s6_v_q      <= s5_v_q;
      s6_gate_q   <= s5_gate_q;
      s6_g_q      <= s5_g_q;
      s6_dinner_q <= s5_dinner_q;
      s6_ka_q     <= t6_last ? LastIdx : t6_k[IdxW-1:0];
      s6_kb_q     <= t6_last ? LastIdx : t6_k[IdxW-1:0] + IdxW'(1);
      s6_frac_q   <= t6_last ? 16'd0 : t6_pos[15:0];
    end
  end

  // stage 7: table read
  logic               s7_mode_q;
  logic signed [23:0] s7_v_q;
  logic signed [15:0] s7_gate_q, s7_g_q;
  logic signed [29:0] s7_dinner_q;
  logic signed [17:0] s7_a_q, s7_b_q;
  logic [15:0]        s7_frac_q;
  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      s7_mode_q   <= s6_mode_q;
      s7_v_q      <= s6_v_q;
      s7_gate_q   <= s6_gate_q;
      s7_g_q      <= s6_g_q;
      s7_dinner_q <= s6_dinner_q;
      s7_a_q      <= swi ? SigTab[s6_ka_q] : TanhTab[s6_ka_q];
      s7_b_q      <= swi ? SigTab[s6_kb_q] : TanhTab[s6_kb_q];
      s7_frac_q   <= s6_frac_q;
    end
  end

  // stage 8: interpolation, f is tanh (GELU) or sigmoid (SwiGLU)
  logic               s8_mode_q;
  logic signed [23:0] s8_v_q;
  logic signed [15:0] s8_gate_q, s8_g_q;
  logic signed [29:0] s8_dinner_q;
  logic signed [17:0] s8_f_q;
  logic signed [16:0] t8_fr;
  logic signed [63:0] t8_f;
  assign t8_fr = signed'({1'b0, s7_frac_q});
  assign t8_f  = s7_a_q + rnd_shift((s7_b_q - s7_a_q) * t8_fr, 16);
  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      s8_mode_q   <= s7_mode_q;
      s8_v_q      <= s7_v_q;
      s8_gate_q   <= s7_gate_q;
      s8_g_q      <= s7_g_q;
      s8_dinner_q <= s7_dinner_q;
      s8_f_q      <= t8_f[17:0];
    end
  end

  // stage 9
  logic               s9_mode_q;
  logic signed [23:0] s9_v_q;
  logic signed [15:0] s9_gate_q, s9_g_q;
  logic signed [29:0] s9_dinner_q;
  logic signed [17:0] s9_f_q, s9_f2_q;
  logic signed [42:0] s9_m_q;
  logic signed [41:0] s9_silu_q;
  logic signed [24:0] s9_t_q;
  logic signed [63:0] t9_m, t9_f2, t9_silu, t9_t;
  assign t9_m    = s8_v_q * (ONE_Q16 + s8_f_q);
  assign t9_f2   = rnd_shift(s8_f_q * s8_f_q, 16);
  assign t9_silu = s8_v_q * s8_f_q;
  assign t9_t    = rnd_shift(s8_v_q * (ONE_Q16 - s8_f_q), 16);
  always_ff @(posedge clk_i) begin
    if (en[8]) begin
      s9_mode_q   <= s8_mode_q;
      s9_v_q      <= s8_v_q;
      s9_gate_q   <= s8_gate_q;
      s9_g_q      <= s8_g_q;
      s9_dinner_q <= s8_dinner_q;
      s9_f_q      <= s8_f_q;
      s9_f2_q     <= t9_f2[17:0];
      s9_m_q      <= t9_m[42:0];
      s9_silu_q   <= t9_silu[41:0];
      s9_t_q      <= t9_t[24:0];
    end
  end

  // stage 10
  logic               s10_mode_q;
  logic signed [15:0] s10_g_q;
  logic signed [29:0] s10_dinner_q;
  logic signed [17:0] s10_f_q;
  logic signed [24:0] s10_p_q;
  logic signed [57:0] s10_prod_q, s10_gprod_q;
  logic signed [25:0] s10_ds_q;
  logic signed [31:0] s10_gg_q;
  logic signed [63:0] t10_p, t10_prod, t10_ds, t10_gprod, t10_gg;
  assign t10_p     = rnd_shift(s9_v_q * (ONE_Q16 - s9_f2_q), 16);
  assign t10_prod  = swi ? s9_silu_q * s9_gate_q : 64'(s9_m_q);
  assign t10_ds    = rnd_shift(s9_f_q * (ONE_Q16 + s9_t_q), 16);
  assign t10_gprod = s9_g_q * s9_silu_q;
  assign t10_gg    = s9_g_q * s9_gate_q;
  always_ff @(posedge clk_i) begin
    if (en[9]) begin
      s10_mode_q   <= s9_mode_q;
      s10_g_q      <= s9_g_q;
      s10_dinner_q <= s9_dinner_q;
      s10_f_q      <= s9_f_q;
      s10_p_q      <= t10_p[24:0];
      s10_prod_q   <= t10_prod[57:0];
      s10_ds_q     <= t10_ds[25:0];
      s10_gprod_q  <= t10_gprod[57:0];
      s10_gg_q     <= t10_gg[31:0];
    end
  end

  // stage 11: 2*GELU'(v), or SwiGLU gradient product
  logic               s11_mode_q;
  logic signed [15:0] s11_g_q;
  logic signed [36:0] s11_dg2_q;
  logic signed [57:0] s11_prod_q, s11_gprod_q;
  logic signed [63:0] t11_dg2, t11_prod;
  assign t11_dg2  = ONE_Q16 + s10_f_q + rnd_shift(s10_p_q * s10_dinner_q, 16);
  assign t11_prod = (swi && s10_mode_q == MODE_BWD) ? s10_gg_q * s10_ds_q
                                                    : 64'(s10_prod_q);
  always_ff @(posedge clk_i) begin
    if (en[10]) begin
      s11_mode_q  <= s10_mode_q;
      s11_g_q     <= s10_g_q;
      s11_dg2_q   <= t11_dg2[36:0];
      s11_prod_q  <= t11_prod[57:0];
      s11_gprod_q <= s10_gprod_q;
    end
  end

  // stage 12
  logic               s12_mode_q;
  logic signed [57:0] s12_prod_q, s12_gprod_q;
  logic signed [63:0] t12_prod;
  assign t12_prod = (!swi && s11_mode_q == MODE_BWD) ? s11_g_q * s11_dg2_q
                                                     : 64'(s11_prod_q);
  always_ff @(posedge clk_i) begin
    if (en[11]) begin
      s12_mode_q  <= s11_mode_q;
      s12_prod_q  <= t12_prod[57:0];
      s12_gprod_q <= s11_gprod_q;
    end
  end

  // stage 13: final rounding, saturation, output register
  logic signed [63:0] t13_main, t13_gate;
  logic               t13_sat_m, t13_sat_g;
  logic signed [15:0] t13_main_s, t13_gate_s;
  always_comb begin
    case ({swi, s12_mode_q})
      2'b00:   t13_main = rnd_shift(s12_prod_q, 25);
      2'b01:   t13_main = rnd_shift(s12_prod_q, 17);
      2'b10:   t13_main = rnd_shift(s12_prod_q, 32);
      default: t13_main = rnd_shift(s12_prod_q, 24);
    endcase
    t13_gate   = (swi && s12_mode_q == MODE_BWD) ? rnd_shift(s12_gprod_q, 32) : 64'sd0;
    t13_sat_m  = (t13_main > 64'sd32767) || (t13_main < -64'sd32768);
    t13_sat_g  = (t13_gate > 64'sd32767) || (t13_gate < -64'sd32768);
    t13_main_s = t13_sat_m ? (t13_main < 0 ? -16'sd32768 : 16'sd32767) : t13_main[15:0];
    t13_gate_s = t13_sat_g ? (t13_gate < 0 ? -16'sd32768 : 16'sd32767) : t13_gate[15:0];
  end
  always_ff @(posedge clk_i) begin
    if (en[12]) begin
      main_result_o <= t13_main_s;
      gate_grad_o   <= t13_gate_s;
      saturated_o   <= t13_sat_m || t13_sat_g;
    end
  end

  // the input side only stalls with every stage holding an item
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_stall_o |-> &vld_q)
    else $error("input stalled with an empty stage");
  // a held result keeps its value and its valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[NumStages-1] && out_stall_i |=> vld_q[NumStages-1] && $stable(main_result_o)
      && $stable(gate_grad_o))
    else $error("stalled result lost or changed");
  // GELU never produces a gate gradient
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_q == ACT_GELU |-> gate_grad_o == 16'sd0)
    else $error("gate gradient nonzero under GELU");
  // the second-to-last stage, holding an item that cannot move, keeps it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[NumStages-2] && !en[NumStages-1] |=> vld_q[NumStages-2])
    else $error("item dropped in pipeline");

endmodule
